// ===== hdl/ultrasonic_range_indicator_macros.svh =====
`ifndef ULTRASONIC_RANGE_INDICATOR_MACROS_SVH
`define ULTRASONIC_RANGE_INDICATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define URI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define URI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/uri_pkg.sv =====
`timescale 1ns / 1ps

package uri_pkg;

    localparam int ECHO_COUNT_BITS = 16;
    localparam int STEP_BITS       = $clog2(ECHO_COUNT_BITS + 1);
    localparam int CNT_BITS        = 20;
    localparam int RANGE_BITS      = 16;
    localparam int ADDR_BITS       = 4;
    localparam int DATA_BITS       = 32;

    localparam logic [1:0] REG_NEAR_LIMIT     = 2'd0;
    localparam logic [1:0] REG_TRIGGER_TICKS  = 2'd1;
    localparam logic [1:0] REG_HOLDOFF_TICKS  = 2'd2;
    localparam logic [1:0] REG_TICKS_PER_UNIT = 2'd3;

    localparam logic [15:0] NEAR_LIMIT_RST     = 16'd100;
    localparam logic [7:0]  TRIGGER_TICKS_RST  = 8'd19;
    localparam logic [19:0] HOLDOFF_TICKS_RST  = 20'd312500;
    localparam logic [15:0] TICKS_PER_UNIT_RST = 16'd40;

    localparam logic [RANGE_BITS-1:0] RANGE_MAX   = 16'hFFFF;
    localparam logic [RANGE_BITS-1:0] DIGIT_LIMIT = 16'd100;

    typedef struct packed {
        logic [15:0] near_limit;
        logic [7:0]  trigger_ticks;
        logic [19:0] holdoff_ticks;
        logic [15:0] ticks_per_unit;
    } cfg_t;

    typedef struct packed {
        logic cnt_inc;
        logic cnt_clr;
        logic echo_set;
        logic echo_inc;
        logic div_start;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic trig_done;
        logic hold_done;
        logic div_done;
    } status_t;

endpackage

// ===== hdl/uri_channels.sv =====
`timescale 1ns / 1ps

interface uri_tick_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink (input valid, input echo_level, output ready);
endinterface

interface uri_result_if;
    logic        valid;
    logic        ready;
    logic        trigger_out;
    logic        report_valid;
    logic [15:0] range_value;
    logic        red_lamp;
    logic        green_lamp;
    logic        point_lamp;
    logic [7:0]  display_byte;

    modport source (
        output valid, output trigger_out, output report_valid, output range_value,
        output red_lamp, output green_lamp, output point_lamp, output display_byte,
        input ready
    );
    modport sink (
        input valid, input trigger_out, input report_valid, input range_value,
        input red_lamp, input green_lamp, input point_lamp, input display_byte,
        output ready
    );
endinterface

// ===== hdl/ultrasonic_range_indicator.sv =====
// Each accepted tick's result is registered and offered in the next cycle;
// the report tick's result waits for the divider and a free output slot.
// Throughput: one tick per cycle while the result slot is free; after the
// report tick it takes no tick until the one-bit-per-cycle divider is done.
// Reset (rst_n low, async): trigger phase, counters and lamps cleared,
// registers to defaults; no clearing pass.
`timescale 1ns / 1ps

module ultrasonic_range_indicator
    import uri_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    uri_tick_if.sink             tick_ch,
    uri_result_if.source         result_ch,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t st;

    uri_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uri_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_ch.valid),
        .echo_level   (tick_ch.echo_level),
        .tick_ready   (tick_ch.ready),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .trigger_out  (result_ch.trigger_out),
        .report_valid (result_ch.report_valid),
        .st           (st),
        .cmd          (cmd)
    );

    uri_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .st           (st),
        .range_value  (result_ch.range_value),
        .red_lamp     (result_ch.red_lamp),
        .green_lamp   (result_ch.green_lamp),
        .point_lamp   (result_ch.point_lamp),
        .display_byte (result_ch.display_byte)
    );

endmodule

// ===== hdl/uri_cfg.sv =====
`timescale 1ns / 1ps

module uri_cfg
    import uri_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    logic [15:0] near_limit_reg;
    logic [7:0]  trigger_ticks_reg;
    logic [19:0] holdoff_ticks_reg;
    logic [15:0] ticks_per_unit_reg;
    logic [1:0]  reg_index;
    logic        wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_limit_reg     <= NEAR_LIMIT_RST;
            trigger_ticks_reg  <= TRIGGER_TICKS_RST;
            holdoff_ticks_reg  <= HOLDOFF_TICKS_RST;
            ticks_per_unit_reg <= TICKS_PER_UNIT_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_NEAR_LIMIT:     near_limit_reg     <= pwdata[15:0];
                REG_TRIGGER_TICKS:  trigger_ticks_reg  <= pwdata[7:0];
                REG_HOLDOFF_TICKS:  holdoff_ticks_reg  <= pwdata[19:0];
                REG_TICKS_PER_UNIT: ticks_per_unit_reg <= pwdata[15:0];
                default:            ticks_per_unit_reg <= ticks_per_unit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_NEAR_LIMIT:     prdata = {16'd0, near_limit_reg};
            REG_TRIGGER_TICKS:  prdata = {24'd0, trigger_ticks_reg};
            REG_HOLDOFF_TICKS:  prdata = {12'd0, holdoff_ticks_reg};
            REG_TICKS_PER_UNIT: prdata = {16'd0, ticks_per_unit_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.near_limit     = near_limit_reg;
    assign cfg.trigger_ticks  = trigger_ticks_reg;
    assign cfg.holdoff_ticks  = holdoff_ticks_reg;
    assign cfg.ticks_per_unit = ticks_per_unit_reg;

endmodule

// ===== hdl/uri_dp.sv =====
`timescale 1ns / 1ps

module uri_dp
    import uri_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  cmd_t                  cmd,
    output status_t               st,
    output logic [RANGE_BITS-1:0] range_value,
    output logic                  red_lamp,
    output logic                  green_lamp,
    output logic                  point_lamp,
    output logic [7:0]            display_byte
);

    logic [CNT_BITS-1:0]        cnt_reg;
    logic [CNT_BITS-1:0]        cnt_plus;
    logic [CNT_BITS-1:0]        trig_need;
    logic [ECHO_COUNT_BITS-1:0] echo_reg;

    // bit-serial restoring divider
    logic [ECHO_COUNT_BITS-1:0] quo_reg;
    logic [15:0]                rem_reg;
    logic [STEP_BITS-1:0]       step_reg;
    logic [16:0]                rem_sh;
    logic [16:0]                rem_sub;
    logic                       fits;

    logic [RANGE_BITS-1:0] range_reg;
    logic                  red_reg;
    logic                  green_reg;
    logic                  point_reg;
    logic [7:0]            display_reg;

    logic [31:0]           quo_ext;
    logic [RANGE_BITS-1:0] range_calc;
    logic [6:0]            d7;
    logic [14:0]           tens_prod;
    logic [3:0]            tens;
    logic [6:0]            units;

    assign cnt_plus  = cnt_reg + 1'b1;
    assign trig_need = (cfg.trigger_ticks == 8'd0) ? CNT_BITS'(1)
                                                   : CNT_BITS'(cfg.trigger_ticks);

    assign st.trig_done = (cnt_plus >= trig_need);
    assign st.hold_done = (cnt_reg >= cfg.holdoff_ticks);
    assign st.div_done  = (step_reg == STEP_BITS'(0));

    assign rem_sh  = {rem_reg, quo_reg[ECHO_COUNT_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, cfg.ticks_per_unit};
    assign fits    = (rem_sh >= {1'b0, cfg.ticks_per_unit});

    assign quo_ext = 32'(quo_reg);
    always_comb
    begin
        if (cfg.ticks_per_unit == 16'd0 || quo_ext > 32'(RANGE_MAX))
            range_calc = RANGE_MAX;
        else
            range_calc = quo_ext[RANGE_BITS-1:0];
    end

    // tens = d / 10 by reciprocal, exact for d below 100
    assign d7        = range_calc[6:0];
    assign tens_prod = {8'd0, d7} * 15'd205;
    assign tens      = tens_prod[14:11];
    assign units     = d7 - ({tens, 3'b000} + {2'b00, tens, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            echo_reg    <= '0;
            step_reg    <= '0;
            range_reg   <= '0;
            red_reg     <= 1'b0;
            green_reg   <= 1'b0;
            point_reg   <= 1'b0;
            display_reg <= '0;
        end
        else
        begin
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_plus;

            if (cmd.echo_set)
                echo_reg <= ECHO_COUNT_BITS'(1);
            else if (cmd.echo_inc)
                echo_reg <= echo_reg + 1'b1;

            if (cmd.div_start)
                step_reg <= STEP_BITS'(ECHO_COUNT_BITS);
            else if (step_reg != STEP_BITS'(0))
                step_reg <= step_reg - 1'b1;

            if (cmd.commit)
            begin
                range_reg <= range_calc;
                if (range_calc < cfg.near_limit)
                begin
                    red_reg   <= 1'b1;
                    green_reg <= 1'b0;
                end
                else
                begin
                    red_reg   <= 1'b0;
                    green_reg <= !green_reg;
                end
                if (range_calc < DIGIT_LIMIT)
                begin
                    point_reg   <= 1'b0;
                    display_reg <= {tens, units[3:0]};
                end
                else
                begin
                    point_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= echo_reg;
            rem_reg <= '0;
        end
        else if (step_reg != STEP_BITS'(0))
        begin
            quo_reg <= {quo_reg[ECHO_COUNT_BITS-2:0], fits};
            rem_reg <= fits ? rem_sub[15:0] : rem_sh[15:0];
        end
    end

    assign range_value  = range_reg;
    assign red_lamp     = red_reg;
    assign green_lamp   = green_reg;
    assign point_lamp   = point_reg;
    assign display_byte = display_reg;

endmodule

// ===== hdl/uri_ctrl.sv =====
`timescale 1ns / 1ps

`include "ultrasonic_range_indicator_macros.svh"

module uri_ctrl
    import uri_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tick_valid,
    input  logic    echo_level,
    output logic    tick_ready,
    output logic    result_valid,
    input  logic    result_ready,
    output logic    trigger_out,
    output logic    report_valid,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_TRIG,
        S_WAIT,
        S_MEAS,
        S_HOLD,
        S_DIV
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   trig_reg;
    logic   report_reg;
    logic   slot_free;
    logic   acc;
    logic   emit;
    logic   emit_trig;
    logic   emit_report;

    assign slot_free  = !out_valid_reg || result_ready;
    assign tick_ready = (state_reg != S_DIV) && slot_free;
    assign acc        = tick_valid && tick_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        emit        = 1'b0;
        emit_trig   = 1'b0;
        emit_report = 1'b0;
        case (state_reg)
            S_TRIG:
            begin
                if (acc)
                begin
                    emit        = 1'b1;
                    emit_trig   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    if (st.trig_done)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                if (acc)
                begin
                    emit = 1'b1;
                    if (echo_level)
                    begin
                        cmd.echo_set = 1'b1;
                        state_next   = S_MEAS;
                    end
                end
            end
            S_MEAS:
            begin
                if (acc)
                begin
                    emit = 1'b1;
                    if (echo_level)
                        cmd.echo_inc = 1'b1;
                    else
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (acc)
                begin
                    if (st.hold_done)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (st.div_done && slot_free)
                begin
                    emit        = 1'b1;
                    emit_report = 1'b1;
                    cmd.commit  = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_TRIG;
                end
            end
            default:
            begin
                state_next = S_TRIG;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_TRIG;
            out_valid_reg <= 1'b0;
            trig_reg      <= 1'b0;
            report_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                trig_reg      <= emit_trig;
                report_reg    <= emit_report;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign trigger_out  = trig_reg;
    assign report_valid = report_reg;

    `URI_ASSERT_NOW(a_div_blocks_ticks, state_reg == S_DIV, !tick_ready,
        "tick taken while dividing")
    `URI_ASSERT_NEXT(a_div_starts, cmd.div_start, state_reg == S_DIV && !st.div_done,
        "divider did not start")
    `URI_ASSERT_NEXT(a_commit_reports, cmd.commit,
        out_valid_reg && report_reg && !trig_reg && state_reg == S_TRIG,
        "report transfer not staged")

endmodule

// ===== sim/range_report_checker.sv =====
`timescale 1ns / 1ps

module range_report_checker
    import uri_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    uri_tick_if                  tick_mon,
    uri_result_if                result_mon,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output int                   mismatches,
    output int                   outstanding,
    output int                   ticks_seen,
    output int                   near_reports,
    output int                   far_reports
);

    typedef enum logic [1:0] {
        PINGING,
        LISTENING,
        TIMING,
        SETTLING
    } sonar_phase_e;

    typedef struct packed {
        logic        trigger_out;
        logic        report_valid;
        logic [15:0] range_value;
        logic        red_lamp;
        logic        green_lamp;
        logic        point_lamp;
        logic [7:0]  display_byte;
    } readout_t;

    cfg_t                       knobs;
    sonar_phase_e               phase;
    logic [CNT_BITS-1:0]        span;
    logic [ECHO_COUNT_BITS-1:0] echo_ticks;
    readout_t                   held;
    readout_t                   readouts_due[$];

    function automatic readout_t advance_sonar(input logic echo);
        readout_t        r;
        logic [7:0]      pulse_need;
        longint unsigned quotient;
        logic [15:0]     tens;
        logic [15:0]     units;
        r = held;
        r.trigger_out = 1'b0;
        r.report_valid = 1'b0;
        case (phase)
            PINGING:
            begin
                r.trigger_out = 1'b1;
                pulse_need = (knobs.trigger_ticks == '0) ? 8'd1 : knobs.trigger_ticks;
                span = span + 1'b1;
                if (span >= pulse_need)
                begin
                    phase = LISTENING;
                    span = '0;
                end
            end
            LISTENING:
            begin
                if (echo)
                begin
                    echo_ticks = 1;
                    phase = TIMING;
                end
            end
            TIMING:
            begin
                if (echo)
                    echo_ticks = echo_ticks + 1'b1;
                else
                begin
                    phase = SETTLING;
                    span = '0;
                end
            end
            default:
            begin
                if (span >= knobs.holdoff_ticks)
                begin
                    if (knobs.ticks_per_unit == '0)
                        quotient = 65535;
                    else
                        quotient = longint'(echo_ticks) / longint'(knobs.ticks_per_unit);
                    if (quotient > 65535)
                        quotient = 65535;
                    held.range_value = quotient[15:0];
                    if (held.range_value < knobs.near_limit)
                    begin
                        held.red_lamp = 1'b1;
                        held.green_lamp = 1'b0;
                        near_reports++;
                    end
                    else
                    begin
                        held.red_lamp = 1'b0;
                        held.green_lamp = ~held.green_lamp;
                        far_reports++;
                    end
                    if (held.range_value < DIGIT_LIMIT)
                    begin
                        tens = held.range_value / 10;
                        units = held.range_value % 10;
                        held.point_lamp = 1'b0;
                        held.display_byte = {tens[3:0], units[3:0]};
                    end
                    else
                        held.point_lamp = 1'b1;
                    r = held;
                    r.trigger_out = 1'b0;
                    r.report_valid = 1'b1;
                    phase = PINGING;
                    span = '0;
                end
                else
                    span = span + 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic void flag_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : watch
        readout_t want;
        if (!rst_n)
        begin
            knobs.near_limit = NEAR_LIMIT_RST;
            knobs.trigger_ticks = TRIGGER_TICKS_RST;
            knobs.holdoff_ticks = HOLDOFF_TICKS_RST;
            knobs.ticks_per_unit = TICKS_PER_UNIT_RST;
            phase = PINGING;
            span = '0;
            echo_ticks = '0;
            held = '0;
            readouts_due.delete();
            mismatches = 0;
            outstanding = 0;
            ticks_seen = 0;
            near_reports = 0;
            far_reports = 0;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                if (readouts_due.size() == 0)
                begin
                    $error("result transfer with no tick awaiting its result");
                    mismatches++;
                end
                else
                begin
                    want = readouts_due.pop_front();
                    flag_field("trigger_out", want.trigger_out, result_mon.trigger_out);
                    flag_field("report_valid", want.report_valid, result_mon.report_valid);
                    flag_field("range_value", want.range_value, result_mon.range_value);
                    flag_field("red_lamp", want.red_lamp, result_mon.red_lamp);
                    flag_field("green_lamp", want.green_lamp, result_mon.green_lamp);
                    flag_field("point_lamp", want.point_lamp, result_mon.point_lamp);
                    flag_field("display_byte", want.display_byte, result_mon.display_byte);
                end
            end
            if (tick_mon.valid && tick_mon.ready)
            begin
                readouts_due.push_back(advance_sonar(tick_mon.echo_level));
                ticks_seen++;
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_BITS-1:2])
                    REG_NEAR_LIMIT:     knobs.near_limit = pwdata[15:0];
                    REG_TRIGGER_TICKS:  knobs.trigger_ticks = pwdata[7:0];
                    REG_HOLDOFF_TICKS:  knobs.holdoff_ticks = pwdata[19:0];
                    REG_TICKS_PER_UNIT: knobs.ticks_per_unit = pwdata[15:0];
                    default:            ;
                endcase
            end
            outstanding = readouts_due.size();
        end
    end

endmodule

// ===== sim/ultrasonic_range_indicator_tb.sv =====
`timescale 1ns / 1ps

module ultrasonic_range_indicator_tb;
    import uri_pkg::*;

    localparam int RANDOM_TICKS  = 400;
    localparam int CALM_TICKS    = 150;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 4000;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    uri_tick_if   tick_ch();
    uri_result_if result_ch();

    int mismatches;
    int outstanding;
    int ticks_seen;
    int near_reports;
    int far_reports;

    cfg_t setting;
    int   sent;
    int   retunes;
    bit   calm;
    bit   squeeze;

    ultrasonic_range_indicator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_ch   (tick_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    range_report_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_mon     (tick_ch),
        .result_mon   (result_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .ticks_seen   (ticks_seen),
        .near_reports (near_reports),
        .far_reports  (far_reports)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pulse_ticks();
        return (setting.trigger_ticks == '0) ? 1 : int'(setting.trigger_ticks);
    endfunction

    task automatic send_tick(input logic echo);
        if (!calm && $urandom_range(7) == 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.echo_level <= echo;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        sent++;
    endtask

    // stop offering ticks and let every result come back
    task automatic drain();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
        case (idx)
            REG_NEAR_LIMIT:     setting.near_limit = value[15:0];
            REG_TRIGGER_TICKS:  setting.trigger_ticks = value[7:0];
            REG_HOLDOFF_TICKS:  setting.holdoff_ticks = value[19:0];
            REG_TICKS_PER_UNIT: setting.ticks_per_unit = value[15:0];
            default:            ;
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic retune(input logic [15:0] near, input logic [7:0] pulse,
                          input logic [19:0] hold, input logic [15:0] unit_ticks);
        drain();
        set_reg(REG_NEAR_LIMIT, near);
        set_reg(REG_TRIGGER_TICKS, pulse);
        set_reg(REG_HOLDOFF_TICKS, hold);
        set_reg(REG_TICKS_PER_UNIT, unit_ticks);
        retunes++;
    endtask

    // one full measurement, starting and ending while the block listens
    task automatic ping(input int lead, input int width);
        repeat (lead) send_tick(1'b0);
        repeat (width) send_tick(1'b1);
        send_tick(1'b0);
        repeat (int'(setting.holdoff_ticks) + 1) send_tick($urandom_range(1));
        repeat (pulse_ticks()) send_tick($urandom_range(1));
    endtask

    // enough low ticks to bring the block back to listening from any phase
    task automatic resync();
        repeat (pulse_ticks() + int'(setting.holdoff_ticks) + 2) send_tick(1'b0);
    endtask

    initial
    begin : result_drain
        int since_squeeze;
        bit squeezed;
        since_squeeze = 0;
        squeezed = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (squeeze && result_ch.valid && result_ch.ready)
                since_squeeze++;
            if (!squeezed && since_squeeze >= 100)
            begin
                squeezed = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(15) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int start;
        int phase_end;
        int unit;
        int width;

        sent = 0;
        retunes = 0;
        calm = 1'b0;
        squeeze = 1'b0;
        setting.near_limit = NEAR_LIMIT_RST;
        setting.trigger_ticks = TRIGGER_TICKS_RST;
        setting.holdoff_ticks = HOLDOFF_TICKS_RST;
        setting.ticks_per_unit = TICKS_PER_UNIT_RST;
        rst_n <= 1'b0;
        tick_ch.valid <= 1'b0;
        tick_ch.echo_level <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: echo high during trigger is ignored, then cut the holdoff short
        repeat (pulse_ticks()) send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        repeat (5) send_tick(1'b1);
        repeat (30) send_tick(1'b0);
        drain();
        set_reg(REG_HOLDOFF_TICKS, 0);
        send_tick(1'b0);
        repeat (pulse_ticks()) send_tick($urandom_range(1));

        // lamp and display boundaries
        retune(50, 2, 1, 1);
        ping(0, 49);
        ping(1, 50);
        ping(2, 99);
        ping(0, 100);
        ping(3, 1);
        retune(0, 1, 0, 1);
        ping(0, 1);

        // zero trigger length
        retune(16'hFFFF, 0, 3, 1);
        ping(1, 60);

        // zero divisor saturates, largest divisor and longest trigger
        retune(100, 4, 2, 0);
        ping(0, 10);
        retune(1000, 8'hFF, 0, 16'hFFFF);
        ping(0, 20);
        retune(100, 1, 0, 7);
        ping(0, 70);

        // lower the trigger length while the trigger is running
        retune(100, 8'hFF, 0, 7);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        repeat (10) send_tick($urandom_range(1));
        drain();
        set_reg(REG_TRIGGER_TICKS, 3);
        send_tick($urandom_range(1));

        // longest holdoff, then lowered mid-holdoff
        drain();
        set_reg(REG_HOLDOFF_TICKS, 20'hFFFFF);
        repeat (3) send_tick(1'b1);
        repeat (40) send_tick(1'b0);
        drain();
        set_reg(REG_HOLDOFF_TICKS, 2);
        send_tick(1'b0);
        repeat (pulse_ticks()) send_tick($urandom_range(1));

        squeeze = 1'b1;
        start = sent;
        while (sent - start < RANDOM_TICKS)
        begin
            retune(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(160),
                   $urandom_range(1, 8), $urandom_range(0, 6),
                   ($urandom_range(7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 3));
            phase_end = sent + 260;
            while (sent < phase_end && sent - start < RANDOM_TICKS)
            begin
                if (sent - start > RANDOM_TICKS - CALM_TICKS)
                    calm = 1'b1;
                if ($urandom_range(6) == 0)
                begin
                    repeat ($urandom_range(1, 20)) send_tick($urandom_range(1));
                    resync();
                end
                else
                begin
                    unit = (setting.ticks_per_unit > 3) ? 3 : int'(setting.ticks_per_unit);
                    width = $urandom_range(1) ? $urandom_range(1, 20 * unit)
                                              : $urandom_range(1, 130 * unit);
                    ping($urandom_range(0, 4), width);
                end
            end
        end

        calm = 1'b1;
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d echo ticks over %0d register settings.", ticks_seen, retunes + 1);
        $display("Distance reports: %0d near, %0d at or beyond the limit.",
                 near_reports, far_reports);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
